### rtl/core/cvt_pkg.sv
// Shared constants and types for the collinear vertex test unit.
`default_nettype none
package cvt_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int INDEX_BITS_DEF = 20;
  localparam int CUTOFF_W = 15;
  localparam int CUTOFF_SQ_W = 2 * CUTOFF_W;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 15'd2577;
  localparam logic [CUTOFF_SQ_W-1:0] CUTOFF_SQ_RESET = CUTOFF_SQ_W'(2577 * 2577);
  localparam int UNIT_FRAC = 14;
  localparam int QUOT_W = UNIT_FRAC + 1;

  typedef enum logic [1:0] {
    VERD_NOT_TWO = 2'd0,
    VERD_DEGEN   = 2'd1,
    VERD_BEND    = 2'd2,
    VERD_MARK    = 2'd3
  } verdict_t;
endpackage
`default_nettype wire

### rtl/core/collinear_vertex_test_unit.sv
// Pipeline: differences, squares, sums, root, divide, direction sum, squares, compare.
// Throughput: one word per cycle while unstalled; root and divider take one bit per stage.
// A stalled output word freezes the whole pipeline; the input takes words otherwise.
// Reset (synchronous, active low) clears valid bits and sets cutoff to 2577.
// Cutoff squared is registered on a cfg write and used by words reaching the compare after it.
`default_nettype none
module collinear_vertex_test_unit #(
  parameter int COORD_BITS = cvt_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS = cvt_pkg::INDEX_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [INDEX_BITS-1:0]        in_vertex_index,
  input  wire logic                         in_two_edges,
  input  wire logic signed [COORD_BITS-1:0] in_center_x,
  input  wire logic signed [COORD_BITS-1:0] in_center_y,
  input  wire logic signed [COORD_BITS-1:0] in_center_z,
  input  wire logic signed [COORD_BITS-1:0] in_first_x,
  input  wire logic signed [COORD_BITS-1:0] in_first_y,
  input  wire logic signed [COORD_BITS-1:0] in_first_z,
  input  wire logic signed [COORD_BITS-1:0] in_second_x,
  input  wire logic signed [COORD_BITS-1:0] in_second_y,
  input  wire logic signed [COORD_BITS-1:0] in_second_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [INDEX_BITS-1:0]             out_vertex_tag,
  output logic                              out_redundant,
  output logic [1:0]                        out_verdict,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [cvt_pkg::CUTOFF_W-1:0] cfg_cutoff
);
  import cvt_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int SQ_W = 2 * COORD_BITS + 3;
  localparam int NST  = 3 + DW + QUOT_W + 2;
  localparam int SM_W = QUOT_W + 1;
  localparam int SS_W = 2 * SM_W - 1;
  localparam int AC_W = SS_W + 2;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic                  te;
    logic [5:0]            neg;
    logic [5:0][DW-1:0]    mag;
  } sq_side_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic                  te;
    logic                  degen;
    logic [5:0]            neg;
  } dv_side_t;

  logic en;
  logic vld_r [NST];
  logic [CUTOFF_SQ_W-1:0] cutoff_sq_r;

  logic signed [COORD_BITS-1:0] pt [9];
  logic [DW-1:0] mag_nxt [6];
  logic [5:0]    neg_nxt;

  sq_side_t s1_r, s2_r, s3_r;
  logic [SQ_W-1:0] sq2_r [6];
  logic [SQ_W-1:0] sum3_r [2];
  sq_side_t sd_r [DW];
  logic [DW-1:0] root [2];
  dv_side_t dv_in;
  dv_side_t dd_r [QUOT_W];
  logic [QUOT_W-1:0] quot [6];
  dv_side_t sa_r, sb_r;
  logic [SM_W-1:0] smag_nxt [3];
  logic [SM_W-1:0] smag_r [3];
  logic [SS_W-1:0] ssq_r [3];
  logic [AC_W-1:0] acc;
  verdict_t verdict_nxt;

  logic out_valid_r;
  logic [INDEX_BITS-1:0] out_tag_r;
  verdict_t out_verdict_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_sq_r <= CUTOFF_SQ_RESET;
    end else if (cfg_valid) begin
      cutoff_sq_r <= CUTOFF_SQ_W'(cfg_cutoff) * CUTOFF_SQ_W'(cfg_cutoff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
      out_valid_r <= vld_r[NST-1];
    end
  end

  assign pt[0] = in_center_x;
  assign pt[1] = in_center_y;
  assign pt[2] = in_center_z;
  assign pt[3] = in_first_x;
  assign pt[4] = in_first_y;
  assign pt[5] = in_first_z;
  assign pt[6] = in_second_x;
  assign pt[7] = in_second_y;
  assign pt[8] = in_second_z;

  // difference vectors as sign and magnitude
  always_comb begin
    logic signed [DW-1:0] diff;
    diff = '0;
    for (int j = 0; j < 6; j++) begin
      diff       = DW'(pt[(j < 3 ? 3 : 6) + (j % 3)]) - DW'(pt[j % 3]);
      neg_nxt[j] = diff[DW-1];
      mag_nxt[j] = diff[DW-1] ? DW'(-diff) : DW'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.idx <= in_vertex_index;
      s1_r.te  <= in_two_edges;
      s1_r.neg <= neg_nxt;
      for (int j = 0; j < 6; j++) s1_r.mag[j] <= mag_nxt[j];
      s2_r <= s1_r;
      for (int j = 0; j < 6; j++) begin
        sq2_r[j] <= SQ_W'(s1_r.mag[j]) * SQ_W'(s1_r.mag[j]);
      end
      s3_r <= s2_r;
      for (int v = 0; v < 2; v++) begin
        sum3_r[v] <= sq2_r[3*v] + sq2_r[3*v+1] + sq2_r[3*v+2];
      end
      sd_r[0] <= s3_r;
      for (int i = 1; i < DW; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  for (genvar v = 0; v < 2; v++) begin : g_root
    cvt_isqrt #(.IN_W(SQ_W), .OUT_W(DW)) u_isqrt (
      .clk     (clk),
      .en      (en),
      .in_val  (sum3_r[v]),
      .out_root(root[v])
    );
  end

  for (genvar j = 0; j < 6; j++) begin : g_div
    cvt_udiv #(.N_W(DW), .Q_W(QUOT_W)) u_udiv (
      .clk (clk),
      .en  (en),
      .num (sd_r[DW-1].mag[j]),
      .den (root[j / 3]),
      .quot(quot[j])
    );
  end

  always_comb begin
    dv_in.idx   = sd_r[DW-1].idx;
    dv_in.te    = sd_r[DW-1].te;
    dv_in.degen = (root[0] == '0) || (root[1] == '0);
    dv_in.neg   = sd_r[DW-1].neg;
  end

  // add the two unit directions per axis
  always_comb begin
    logic signed [SM_W:0] s;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      s = (dd_r[QUOT_W-1].neg[k] ? -(SM_W+1)'(quot[k]) : (SM_W+1)'(quot[k]))
        + (dd_r[QUOT_W-1].neg[k+3] ? -(SM_W+1)'(quot[k+3]) : (SM_W+1)'(quot[k+3]));
      smag_nxt[k] = s[SM_W] ? SM_W'(-s) : SM_W'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dd_r[0] <= dv_in;
      for (int i = 1; i < QUOT_W; i++) dd_r[i] <= dd_r[i-1];
      sa_r <= dd_r[QUOT_W-1];
      for (int k = 0; k < 3; k++) smag_r[k] <= smag_nxt[k];
      sb_r <= sa_r;
      for (int k = 0; k < 3; k++) begin
        ssq_r[k] <= SS_W'((2 * SM_W)'(smag_r[k]) * (2 * SM_W)'(smag_r[k]));
      end
    end
  end

  always_comb begin
    acc = AC_W'(ssq_r[0]) + AC_W'(ssq_r[1]) + AC_W'(ssq_r[2]);
    if (!sb_r.te) begin
      verdict_nxt = VERD_NOT_TWO;
    end else if (sb_r.degen) begin
      verdict_nxt = VERD_DEGEN;
    end else if (acc <= AC_W'(cutoff_sq_r)) begin
      verdict_nxt = VERD_MARK;
    end else begin
      verdict_nxt = VERD_BEND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag_r     <= sb_r.idx;
      out_verdict_r <= verdict_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_vertex_tag = out_tag_r;
  assign out_verdict    = out_verdict_r;
  assign out_redundant  = (out_verdict_r == VERD_MARK);
endmodule
`default_nettype wire

### rtl/core/cvt_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module cvt_isqrt #(
  parameter int IN_W  = 51,
  parameter int OUT_W = 25
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [IN_W-1:0]  in_val,
  output logic      [OUT_W-1:0] out_root
);
  localparam int TW = IN_W + 1;

  logic [IN_W-1:0]  rem_r  [OUT_W];
  logic [OUT_W-1:0] root_r [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam int B = OUT_W - 1 - k;
    logic [IN_W-1:0]  src_rem;
    logic [OUT_W-1:0] src_root;
    logic [TW-1:0]    trial;
    logic [IN_W-1:0]  rem_nxt;
    logic [OUT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign src_rem  = in_val;
      assign src_root = '0;
    end else begin : g_next
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
    end

    always_comb begin
      trial    = (TW'(src_root) << (B + 1)) + (TW'(1) << (2 * B));
      rem_nxt  = src_rem;
      root_nxt = src_root;
      if (TW'(src_rem) >= trial) begin
        rem_nxt  = src_rem - trial[IN_W-1:0];
        root_nxt = src_root | (OUT_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign out_root = root_r[OUT_W-1];
endmodule
`default_nettype wire

### rtl/core/cvt_udiv.sv
// Pipelined restoring divider for a quotient known to fit in Q_W bits.
`default_nettype none
module cvt_udiv #(
  parameter int N_W = 25,
  parameter int Q_W = 15
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [N_W-1:0] num,
  input  wire logic [N_W-1:0] den,
  output logic      [Q_W-1:0] quot
);
  logic [N_W:0]   rem_r [Q_W];
  logic [N_W-1:0] den_r [Q_W];
  logic [Q_W-1:0] q_r   [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [N_W:0]   src_rem;
    logic [N_W-1:0] src_den;
    logic [Q_W-1:0] src_q;
    logic           ge;
    logic [N_W:0]   diff;

    if (k == 0) begin : g_first
      assign src_rem = {1'b0, num};
      assign src_den = den;
      assign src_q   = '0;
    end else begin : g_next
      assign src_rem = rem_r[k-1];
      assign src_den = den_r[k-1];
      assign src_q   = q_r[k-1];
    end

    always_comb begin
      ge   = src_rem >= {1'b0, src_den};
      diff = ge ? src_rem - {1'b0, src_den} : src_rem;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= {diff[N_W-1:0], 1'b0};
        den_r[k] <= src_den;
        q_r[k]   <= {src_q[Q_W-2:0], ge};
      end
    end
  end

  assign quot = q_r[Q_W-1];
endmodule
`default_nettype wire

### bench/collinear_vertex_test_unit_test.sv
// Self-checking bench for the collinear vertex test unit: predicted verdicts vs. block output.
`default_nettype none
module collinear_vertex_test_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cvt_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int IB = INDEX_BITS_DEF;
  localparam int LATENCY = 3 + (CB + 1) + 15 + 3;
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic [IB-1:0] tag;
    logic          redundant;
    verdict_t      verdict;
  } verdict_word_t;

  typedef logic signed [CB-1:0] coord_t;

  class verdict_board;
    verdict_word_t pending[$];
    logic [CUTOFF_W-1:0] cutoff;
    int errors;

    function new();
      cutoff = CUTOFF_RESET;
      errors = 0;
    endfunction

    function longint unsigned root(logic [127:0] v);
      logic [127:0] r, c;
      r = 0;
      for (int b = 33; b >= 0; b--) begin
        c = r | (128'd1 << b);
        if (c * c <= v) r = c;
      end
      return r[63:0];
    endfunction

    function longint unsigned span(longint dx, longint dy, longint dz);
      logic [127:0] s;
      s = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
      return root(s);
    endfunction

    function longint scale(longint d, longint unsigned len);
      longint unsigned q;
      q = ((d < 0 ? -d : d) * 16384) / len;
      return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function void note_vertex(logic [IB-1:0] idx, logic two, coord_t c[3], coord_t p[3],
                              coord_t q[3]);
      verdict_word_t w;
      longint d1[3], d2[3], s;
      longint unsigned l1, l2, acc;
      w.tag = idx;
      w.redundant = 0;
      if (!two) begin
        w.verdict = VERD_NOT_TWO;
      end else begin
        for (int i = 0; i < 3; i++) begin
          d1[i] = longint'(p[i]) - longint'(c[i]);
          d2[i] = longint'(q[i]) - longint'(c[i]);
        end
        l1 = span(d1[0], d1[1], d1[2]);
        l2 = span(d2[0], d2[1], d2[2]);
        if (l1 == 0 || l2 == 0) begin
          w.verdict = VERD_DEGEN;
        end else begin
          acc = 0;
          for (int i = 0; i < 3; i++) begin
            s = scale(d1[i], l1) + scale(d2[i], l2);
            acc += s * s;
          end
          if (acc <= longint'(cutoff) * longint'(cutoff)) begin
            w.verdict = VERD_MARK;
            w.redundant = 1;
          end else begin
            w.verdict = VERD_BEND;
          end
        end
      end
      pending = {pending, w};
    endfunction

    function void check_word(verdict_word_t got);
      verdict_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word tag=%0d red=%0d verdict=%0d", $time, got.tag,
                 got.redundant, got.verdict);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.tag !== e.tag) begin
        $display("%0t: tag expected %0d actual %0d", $time, e.tag, got.tag);
        errors++;
      end
      if (got.redundant !== e.redundant) begin
        $display("%0t: redundant expected %0d actual %0d", $time, e.redundant, got.redundant);
        errors++;
      end
      if (got.verdict !== e.verdict) begin
        $display("%0t: verdict expected %0d actual %0d", $time, e.verdict, got.verdict);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, in_two_edges = 0;
  logic [IB-1:0] in_vertex_index = 0;
  coord_t in_center_x = 0, in_center_y = 0, in_center_z = 0;
  coord_t in_first_x = 0, in_first_y = 0, in_first_z = 0;
  coord_t in_second_x = 0, in_second_y = 0, in_second_z = 0;
  logic out_valid, out_stall = 0, out_redundant;
  logic [IB-1:0] out_vertex_tag;
  logic [1:0] out_verdict;
  logic cfg_valid = 0, cfg_ready;
  logic [CUTOFF_W-1:0] cfg_cutoff = 0;

  verdict_board board = new();
  int send_idle = 0, recv_idle = 0;
  int hold_off = 0;
  longint cycles = 0;

  collinear_vertex_test_unit u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_word('{tag: out_vertex_tag, redundant: out_redundant,
                         verdict: verdict_t'(out_verdict)});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_vertex(logic [IB-1:0] idx, logic two, coord_t c[3], coord_t p[3],
                             coord_t q[3]);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_vertex_index <= idx;
    in_two_edges <= two;
    in_center_x <= c[0]; in_center_y <= c[1]; in_center_z <= c[2];
    in_first_x <= p[0]; in_first_y <= p[1]; in_first_z <= p[2];
    in_second_x <= q[0]; in_second_y <= q[1]; in_second_z <= q[2];
    do @(posedge clk); while (in_stall);
    board.note_vertex(idx, two, c, p, q);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [CUTOFF_W-1:0] v);
    drain();
    cfg_valid <= 1;
    cfg_cutoff <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.cutoff = v;
  endtask

  function automatic coord_t rnd_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(8191)) - 4096);
      2: return $urandom_range(1) ? coord_t'(1 << (CB - 1)) : coord_t'((1 << (CB - 1)) - 1);
      default: return coord_t'($signed($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  task automatic random_vertex();
    coord_t c[3], p[3], q[3], d[3];
    int k, m;
    for (int i = 0; i < 3; i++) c[i] = rnd_coord();
    k = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      d[i] = coord_t'($signed($urandom_range(60000)) - 30000);
      if (k < 6) begin
        // near-straight: second neighbor opposite the first, with jitter
        m = $urandom_range(3) + 1;
        c[i] = coord_t'($signed($urandom_range(1000000)) - 500000);
        p[i] = c[i] + d[i];
        q[i] = coord_t'(c[i] - d[i] * m
                        + coord_t'($signed($urandom_range(2 * k * k)) - k * k));
      end else if (k == 6) begin
        p[i] = c[i];
        q[i] = rnd_coord();
      end else begin
        p[i] = rnd_coord();
        q[i] = rnd_coord();
      end
    end
    send_vertex(IB'($urandom), ($urandom_range(9) != 0), c, p, q);
  endtask

  task automatic directed();
    coord_t z[3], mx[3], mn[3], a[3], b[3];
    z = '{0, 0, 0};
    mx = '{coord_t'((1 << (CB - 1)) - 1), coord_t'((1 << (CB - 1)) - 1),
           coord_t'((1 << (CB - 1)) - 1)};
    mn = '{coord_t'(1 << (CB - 1)), coord_t'(1 << (CB - 1)), coord_t'(1 << (CB - 1))};
    a = '{4096, 0, 0};
    b = '{-4096, 0, 0};
    send_vertex(0, 0, mx, mn, z);
    send_vertex({IB{1'b1}}, 1, z, a, b);
    send_vertex(1, 1, z, z, b);
    send_vertex(2, 1, z, a, z);
    send_vertex(3, 1, mn, mx, mx);
    send_vertex(4, 1, mx, mn, mn);
    send_vertex(5, 1, mx, mn, mx);
    send_vertex(6, 1, z, '{1, 0, 0}, '{-1, 0, 0});
    send_vertex(7, 1, z, '{1, 1, 1}, '{-1, -1, 0});
    send_vertex(8, 1, z, a, '{0, 4096, 0});
    send_vertex(9, 1, z, a, a);
    send_vertex(10, 1, '{100, -200, 300}, '{4196, -200, 300}, '{-3996, -150, 300});
    send_vertex(11, 1, z, mx, mn);
    send_vertex(12, 0, z, z, z);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_cutoff(15'd0);
        1: write_cutoff(15'h7FFF);
        2: write_cutoff(15'd25772);
        3: write_cutoff(CUTOFF_RESET);
        4: write_cutoff(15'($urandom_range(4000)));
        default: write_cutoff(15'd1);
      endcase
      directed();
      for (int i = 0; i < 300; i++) begin
        case (i / 75)
          0: begin send_idle = 0; recv_idle = 0; end
          1: begin send_idle = 81; recv_idle = 0; end
          2: begin send_idle = 0; recv_idle = 81; end
          default: begin send_idle = 32; recv_idle = 32; end
        endcase
        if (ph == 2 && i == 10) hold_off <= 400;
        random_vertex();
      end
      send_idle = 0;
      recv_idle = 0;
    end
    drain();
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
